// ----- design/sat_pkg.sv -----
// Package for the seen address table: item codes, field widths, result struct.
// No dependencies; imported by sat_mem, sat_ctrl and seen_address_table.
`default_nettype none
package sat_pkg;

  localparam int SAT_DEPTH = 20;
  localparam int MAC_W     = 48;
  localparam int RSSI_W    = 8;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int SLOT_W    = 5;
  localparam int UCNT_W    = 5;
  localparam int TOTAL_W   = 16;
  localparam int ENTRY_W   = MAC_W + RSSI_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_POST
  } state_t;

  typedef struct packed {
    logic                     hit;
    logic [SLOT_W-1:0]        slot;
    logic                     evicted;
    logic [UCNT_W-1:0]        unique_count;
    logic [TOTAL_W-1:0]       total_seen;
    logic [MAC_W-1:0]         entry_mac;
    logic signed [RSSI_W-1:0] entry_rssi;
  } res_t;

endpackage
`default_nettype wire

// ----- design/seen_address_table.sv -----
// Seen address table: up to TABLE_DEPTH distinct 48-bit addresses with their
// latest strength, oldest-first replacement, unique and new-address counters.
// A report walks the held entries one per cycle through the single read port of
// the entry memory until it finds the address or has compared them all; read,
// clear and no-operation items do not scan. Results leave through an output
// register, so the next item is taken while a result waits. Depends on
// sat_pkg, sat_mem and sat_ctrl.
`default_nettype none
module seen_address_table
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = SAT_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic [MAC_W-1:0]         in_mac,
  input  wire logic signed [RSSI_W-1:0] in_rssi,
  input  wire logic [INDEX_W-1:0]       in_index,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_hit,
  output logic [SLOT_W-1:0]             out_slot,
  output logic                          out_evicted,
  output logic [UCNT_W-1:0]             out_unique_count,
  output logic [TOTAL_W-1:0]            out_total_seen,
  output logic [MAC_W-1:0]              out_entry_mac,
  output logic signed [RSSI_W-1:0]      out_entry_rssi
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic               out_free;
  logic               res_vld;
  res_t               res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  sat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_mac    (in_mac),
    .in_rssi   (in_rssi),
    .in_index  (in_index),
    .out_free  (out_free),
    .res_vld   (res_vld),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sat_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_vld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_res_r.hit;
  assign out_slot         = out_res_r.slot;
  assign out_evicted      = out_res_r.evicted;
  assign out_unique_count = out_res_r.unique_count;
  assign out_total_seen   = out_res_r.total_seen;
  assign out_entry_mac    = out_res_r.entry_mac;
  assign out_entry_rssi   = out_res_r.entry_rssi;

endmodule
`default_nettype wire

// ----- design/sat_mem.sv -----
// Entry store of the seen address table: one write port, one registered read port.
// Depends on sat_pkg for the entry width.
`default_nettype none
module sat_mem
  import sat_pkg::*;
#(
  parameter int DEPTH  = SAT_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- design/sat_ctrl.sv -----
// Sequencer of the seen address table: entry scan, insert, read and clear, counters.
// Depends on sat_pkg; drives the sat_mem ports and hands results to the output register.
`default_nettype none
module sat_ctrl
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = SAT_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH),
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic [MAC_W-1:0]         in_mac,
  input  wire logic signed [RSSI_W-1:0] in_rssi,
  input  wire logic [INDEX_W-1:0]       in_index,
  input  wire logic                     out_free,
  output logic                          res_vld,
  output res_t                          res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [ENTRY_W-1:0]            mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  wire logic [ENTRY_W-1:0]       mem_rdata
);

  localparam int W = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;
  localparam logic [IDX_W-1:0] LAST_PHYS = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         oldest_r, oldest_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic [MAC_W-1:0]         mac_r, mac_nxt;
  logic signed [RSSI_W-1:0] rssi_r, rssi_nxt;
  logic [CNT_W-1:0]         rd_i_r, rd_i_nxt;
  logic [IDX_W-1:0]         rd_phys_r, rd_phys_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]         cmp_i_r, cmp_i_nxt;
  logic [IDX_W-1:0]         cmp_phys_r, cmp_phys_nxt;
  logic                     inrange_r, inrange_nxt;

  logic             accept;
  logic             cmp_match;
  logic             scan_end;
  logic             fin;
  logic             rd_inrange;
  logic [W-1:0]     rd_sum;
  logic [W-1:0]     rd_wrap;
  logic [CNT_W-1:0] ins_slot;

  assign accept     = in_valid && in_ready;
  assign cmp_match  = cmp_vld_r && (mem_rdata[ENTRY_W-1:RSSI_W] == mac_r);
  assign scan_end   = !cmp_vld_r && (rd_i_r >= count_r);
  assign fin        = cmp_match || scan_end;
  assign rd_inrange = W'(in_index) < W'(count_r);
  assign rd_sum     = W'(in_index) + W'(oldest_r);
  assign rd_wrap    = (rd_sum >= W'(TABLE_DEPTH)) ? rd_sum - W'(TABLE_DEPTH) : rd_sum;
  assign ins_slot   = (count_r < FULL_CNT) ? count_r : LAST_CNT;

  function automatic logic [IDX_W-1:0] phys_inc(input logic [IDX_W-1:0] p);
    phys_inc = (p == LAST_PHYS) ? '0 : p + IDX_W'(1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_REPORT) begin
            state_nxt = ST_SCAN;
          end else if (in_kind == KIND_READ) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_SCAN: begin
        if (fin && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ, ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    count_nxt    = count_r;
    oldest_nxt   = oldest_r;
    total_nxt    = total_r;
    mac_nxt      = mac_r;
    rssi_nxt     = rssi_r;
    rd_i_nxt     = rd_i_r;
    rd_phys_nxt  = rd_phys_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_i_nxt    = cmp_i_r;
    cmp_phys_nxt = cmp_phys_r;
    inrange_nxt  = inrange_r;
    mem_we       = 1'b0;
    mem_waddr    = cmp_phys_r;
    mem_wdata    = {mac_r, rssi_r};
    mem_re       = 1'b0;
    mem_raddr    = rd_phys_r;
    res_vld      = 1'b0;
    res          = '0;
    res.unique_count = UCNT_W'(count_r);
    res.total_seen   = total_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_REPORT) begin
            mac_nxt     = in_mac;
            rssi_nxt    = in_rssi;
            rd_i_nxt    = '0;
            rd_phys_nxt = oldest_r;
            cmp_vld_nxt = 1'b0;
          end else if (in_kind == KIND_READ) begin
            inrange_nxt = rd_inrange;
            mem_re      = rd_inrange;
            mem_raddr   = rd_wrap[IDX_W-1:0];
          end else if (in_kind == KIND_CLEAR) begin
            count_nxt  = '0;
            oldest_nxt = '0;
            total_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        if (!fin) begin
          // issue the next entry read while the previous one is compared
          if (rd_i_r < count_r) begin
            mem_re       = 1'b1;
            cmp_vld_nxt  = 1'b1;
            cmp_i_nxt    = rd_i_r;
            cmp_phys_nxt = rd_phys_r;
            rd_i_nxt     = rd_i_r + CNT_W'(1);
            rd_phys_nxt  = phys_inc(rd_phys_r);
          end else begin
            cmp_vld_nxt = 1'b0;
          end
        end else if (out_free) begin
          res_vld = 1'b1;
          mem_we  = 1'b1;
          if (cmp_match) begin
            mem_waddr = cmp_phys_r;
            res.hit   = 1'b1;
            res.slot  = SLOT_W'(cmp_i_r);
          end else begin
            // rd_phys_r stopped at the youngest-plus-one slot, which is oldest when full
            mem_waddr = rd_phys_r;
            if (total_r != TOTAL_MAX) begin
              total_nxt = total_r + TOTAL_W'(1);
            end
            if (count_r < FULL_CNT) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              oldest_nxt  = phys_inc(oldest_r);
              res.evicted = 1'b1;
            end
            res.slot         = SLOT_W'(ins_slot);
            res.unique_count = UCNT_W'(count_nxt);
            res.total_seen   = total_nxt;
          end
        end
      end
      ST_READ: begin
        res_vld = out_free;
        if (inrange_r) begin
          res.entry_mac  = mem_rdata[ENTRY_W-1:RSSI_W];
          res.entry_rssi = mem_rdata[RSSI_W-1:0];
        end
      end
      ST_POST: begin
        res_vld = out_free;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      oldest_r  <= '0;
      total_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      oldest_r  <= oldest_nxt;
      total_r   <= total_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r      <= mac_nxt;
    rssi_r     <= rssi_nxt;
    rd_i_r     <= rd_i_nxt;
    rd_phys_r  <= rd_phys_nxt;
    cmp_i_r    <= cmp_i_nxt;
    cmp_phys_r <= cmp_phys_nxt;
    inrange_r  <= inrange_nxt;
  end

endmodule
`default_nettype wire
